@@ design/tcfp_pkg.sv @@
// ----------------------------------------------------------------------------
// tcfp_pkg
// Shared codes, reply descriptor type and command length table for the
// test command frame parser.
// ----------------------------------------------------------------------------
package tcfp_pkg;

    // Frame and reply bytes
    localparam logic [7:0] HEAD_BYTE     = 8'hF4;
    localparam logic [7:0] REPLY_LEAD    = 8'h4F;
    localparam logic [7:0] ACK_ONE       = 8'h01;
    localparam logic [7:0] NOT_SUPPORTED = 8'h40;
    localparam logic [7:0] ACK_OK        = 8'hF0;
    localparam logic [7:0] ACK_NG        = 8'hFF;

    // Command codes
    localparam logic [7:0] CMD_GET_TYPE  = 8'h00;
    localparam logic [7:0] CMD_SYNC_RTC  = 8'h01;
    localparam logic [7:0] CMD_LAST_PLAIN = 8'h07;
    localparam logic [7:0] CMD_RF        = 8'h05;
    localparam logic [7:0] CMD_EEPROM    = 8'h06;
    localparam logic [7:0] CMD_ETHERNET  = 8'h07;
    localparam logic [7:0] CMD_LED       = 8'h08;
    localparam logic [7:0] CMD_INIT_I2C  = 8'hF4;

    // Configuration registers
    localparam logic       REG_HW_TYPE   = 1'b0;
    localparam logic [7:0] HW_TYPE_RESET = 8'h0E;

    // Fixed data length of a command
    typedef struct packed {
        logic       known;
        logic [2:0] len;
    } cmd_len_t;

    // One reply: four-byte ack form or three-byte not-supported form
    typedef struct packed {
        logic       four;
        logic [7:0] cmd;
        logic [7:0] data;
        logic       led_write;
        logic [2:0] led_drive;
    } reply_t;

    function automatic cmd_len_t fixed_length(input logic [7:0] c);
        cmd_len_t r;
        r.known = 1'b1;
        r.len   = 3'd0;
        if (c == CMD_SYNC_RTC) begin
            r.len = 3'd6;
        end
        else if (c <= CMD_LAST_PLAIN) begin
            r.len = 3'd0;
        end
        else if (c == CMD_LED) begin
            r.len = 3'd1;
        end
        else if (c == CMD_INIT_I2C) begin
            r.len = 3'd0;
        end
        else begin
            r.known = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ design/tcfp_regs.sv @@
// ----------------------------------------------------------------------------
// tcfp_regs
// APB-style configuration register block holding the hardware type code.
// ----------------------------------------------------------------------------
module tcfp_regs (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  hw_type
);
    import tcfp_pkg::*;

    logic [7:0] hw_type_reg;
    logic       wr_en;

    // Decode the word index; byte lane bits are ignored
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_HW_TYPE);
    assign pready = 1'b1;

    // Hold the type code, load on a write transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_type_reg <= HW_TYPE_RESET;
        end
        else if (wr_en)
        begin
            hw_type_reg <= pwdata[7:0];
        end
    end

    // Read back
    always_comb
    begin
        if (paddr[2] == REG_HW_TYPE)
        begin
            prdata = {24'd0, hw_type_reg};
        end
        else
        begin
            prdata = 32'd0;
        end
    end

    assign hw_type = hw_type_reg;

endmodule

@@ design/tcfp_parser.sv @@
// ----------------------------------------------------------------------------
// tcfp_parser
// Frame state machine: head, command, length and data phases. Builds the
// reply descriptor for the byte in the input register.
// ----------------------------------------------------------------------------
module tcfp_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              stage_valid,
    input  logic              stage_op,
    input  logic [7:0]        stage_byte,
    input  logic              stage_ok,
    input  logic              consume,
    input  logic [7:0]        hw_type,
    output logic              reply_valid,
    output tcfp_pkg::reply_t  reply
);
    import tcfp_pkg::*;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_CMD,
        PH_LEN,
        PH_DATA
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] command_reg, command_next;
    logic [2:0] bytes_left_reg, bytes_left_next;
    logic [7:0] first_data_reg, first_data_next;
    logic       fire;
    cmd_len_t   cl;
    logic [2:0] bl_dec;
    logic [7:0] fd_new;

    assign cl     = fixed_length(command_reg);
    assign bl_dec = (bytes_left_reg != 3'd0) ? bytes_left_reg - 3'd1 : 3'd0;
    assign fd_new = (phase_reg == PH_DATA && cl.known && bytes_left_reg == cl.len)
                    ? stage_byte : first_data_reg;

    // Advance the frame phase for one byte
    always_comb
    begin
        phase_next      = phase_reg;
        command_next    = command_reg;
        bytes_left_next = bytes_left_reg;
        first_data_next = first_data_reg;
        fire            = 1'b0;
        case (phase_reg)
            PH_HEAD:
            begin
                if (stage_byte == HEAD_BYTE)
                begin
                    phase_next = PH_CMD;
                end
            end
            PH_CMD:
            begin
                command_next = stage_byte;
                phase_next   = PH_LEN;
            end
            PH_LEN:
            begin
                if (!cl.known || stage_byte != {5'd0, cl.len})
                begin
                    phase_next = PH_HEAD;
                end
                else if (cl.len != 3'd0)
                begin
                    bytes_left_next = cl.len;
                    phase_next      = PH_DATA;
                end
                else
                begin
                    phase_next = PH_HEAD;
                    fire       = 1'b1;
                end
            end
            PH_DATA:
            begin
                first_data_next = fd_new;
                bytes_left_next = bl_dec;
                if (bl_dec == 3'd0)
                begin
                    phase_next = PH_HEAD;
                    fire       = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_HEAD;
            end
        endcase
        // Receive error: restart, keep stored fields
        if (stage_op)
        begin
            phase_next      = PH_HEAD;
            command_next    = command_reg;
            bytes_left_next = bytes_left_reg;
            first_data_next = first_data_reg;
            fire            = 1'b0;
        end
    end

    assign reply_valid = stage_valid && fire;

    // Build the reply for the stored command
    always_comb
    begin
        reply.four      = 1'b1;
        reply.cmd       = command_reg;
        reply.data      = ACK_NG;
        reply.led_write = 1'b0;
        reply.led_drive = 3'd0;
        case (command_reg)
            CMD_GET_TYPE:
            begin
                reply.data = hw_type;
            end
            CMD_LED:
            begin
                reply.data      = fd_new;
                reply.led_write = 1'b1;
                reply.led_drive = ~fd_new[2:0];
            end
            CMD_RF, CMD_ETHERNET:
            begin
                reply.data = ACK_NG;
            end
            CMD_EEPROM:
            begin
                reply.data = stage_ok ? ACK_OK : ACK_NG;
            end
            default:
            begin
                reply.four = 1'b0;
                reply.data = 8'd0;
            end
        endcase
    end

    // Hold parser state, update when the byte is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEAD;
            command_reg    <= 8'd0;
            bytes_left_reg <= 3'd0;
            first_data_reg <= 8'd0;
        end
        else if (consume)
        begin
            phase_reg      <= phase_next;
            command_reg    <= command_next;
            bytes_left_reg <= bytes_left_next;
            first_data_reg <= first_data_next;
        end
    end

    a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (bytes_left_reg != 3'd0))
        else $error("data phase with no bytes left");

    a_no_reply_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid && stage_op) |-> !reply_valid)
        else $error("reply raised on receive error");

endmodule

@@ design/tcfp_serializer.sv @@
// ----------------------------------------------------------------------------
// tcfp_serializer
// Holds one reply descriptor and sends its three or four bytes, one per
// output transaction.
// ----------------------------------------------------------------------------
module tcfp_serializer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  tcfp_pkg::reply_t  reply,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        tx_byte,
    output logic              tx_last,
    output logic              led_write,
    output logic [2:0]        led_drive
);
    import tcfp_pkg::*;

    reply_t     desc_reg;
    logic       busy_reg;
    logic [1:0] idx_reg;
    logic       last;

    assign last = desc_reg.four ? (idx_reg == 2'd3) : (idx_reg == 2'd2);
    assign free = !busy_reg || (out_ready && last);

    // Hold descriptor payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            desc_reg <= reply;
        end
    end

    // Advance byte index on each output transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end
        else if (busy_reg && out_ready)
        begin
            if (last)
            begin
                busy_reg <= 1'b0;
                idx_reg  <= 2'd0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // Select the current byte
    always_comb
    begin
        tx_byte = 8'd0;
        if (desc_reg.four)
        begin
            case (idx_reg)
                2'd0:    tx_byte = REPLY_LEAD;
                2'd1:    tx_byte = desc_reg.cmd;
                2'd2:    tx_byte = ACK_ONE;
                default: tx_byte = desc_reg.data;
            endcase
        end
        else if (idx_reg == 2'd0)
        begin
            tx_byte = NOT_SUPPORTED;
        end
    end

    assign out_valid = busy_reg;
    assign tx_last   = last;
    assign led_write = desc_reg.led_write;
    assign led_drive = desc_reg.led_drive;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !out_ready && !load) |=> (busy_reg && $stable(idx_reg)))
        else $error("reply index moved while stalled");

    a_short_index: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !desc_reg.four) |-> (idx_reg != 2'd3))
        else $error("short reply index out of range");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("reply loaded over a pending reply");

endmodule

@@ design/test_command_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// test_command_frame_parser_core
// Byte-wise test command frame parser with reply serializer and APB-style
// configuration register.
// ----------------------------------------------------------------------------
// Reply path: with the serializer free, a frame's final byte is registered in the
//   input register and, once consumed, loads the reply into the serializer; the
//   first reply byte is valid as soon as the reply is loaded.
// Throughput: one received byte per cycle; a reply holds the serializer for
//   3 or 4 output transactions, and a byte that completes a frame waits in
//   the input register until the serializer is free.
// Reset: asynchronous, active low; parser returns to waiting for head,
//   hardware type returns to 0x0E, no reply pending.
// ----------------------------------------------------------------------------
module test_command_frame_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    input  logic        eeprom_test_ok,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  tx_byte,
    output logic        tx_last,
    output logic        led_write,
    output logic [2:0]  led_drive,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tcfp_pkg::*;

    logic       stage_valid_reg;
    logic       stage_op_reg;
    logic [7:0] stage_byte_reg;
    logic       stage_ok_reg;
    logic       consume;
    logic       reply_valid;
    reply_t     reply;
    logic       ser_free;
    logic [7:0] hw_type;

    tcfp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .hw_type (hw_type)
    );

    // Consume the staged byte unless its reply has nowhere to go
    assign consume  = stage_valid_reg && (!reply_valid || ser_free);
    assign in_ready = !stage_valid_reg || consume;

    // Hold the input register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    // Capture the input payload on a transaction
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_op_reg   <= op;
            stage_byte_reg <= rx_byte;
            stage_ok_reg   <= eeprom_test_ok;
        end
    end

    tcfp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid_reg),
        .stage_op    (stage_op_reg),
        .stage_byte  (stage_byte_reg),
        .stage_ok    (stage_ok_reg),
        .consume     (consume),
        .hw_type     (hw_type),
        .reply_valid (reply_valid),
        .reply       (reply)
    );

    tcfp_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (consume && reply_valid),
        .reply     (reply),
        .free      (ser_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tx_byte   (tx_byte),
        .tx_last   (tx_last),
        .led_write (led_write),
        .led_drive (led_drive)
    );

endmodule
